// ----- design/svf_pkg.sv -----
// Shared types, constants and the q table of the state-variable filter step block.
package svf_pkg;

    localparam int DEF_STATE_BITS   = 40;
    localparam int DEF_SAMPLE_BITS  = 18;
    localparam int DEF_LOW_FRAC_MAX = 4;
    localparam int OUT_BITS         = 21;

    localparam int FREQ_BITS = 13;
    localparam int K_BITS    = 9;
    localparam int QM_BITS   = 8;
    localparam int KQ_BITS   = K_BITS + QM_BITS;
    localparam int SH_BASE   = 24;
    localparam int Q_FRAC    = 7;
    localparam int HB_MAX    = 4;

    localparam logic [FREQ_BITS-1:0] FREQ_MANT_MASK = 13'h1FF;
    localparam logic [K_BITS-1:0]    K_BASE         = 9'd256;
    localparam logic [4:0]           Q_INDEX_RESET  = 5'd4;

    localparam logic [QM_BITS-1:0] Q_TABLE [32] = '{
        8'd192, 8'd176, 8'd160, 8'd144, 8'd128, 8'd120, 8'd112, 8'd104,
        8'd96,  8'd88,  8'd80,  8'd72,  8'd64,  8'd60,  8'd56,  8'd52,
        8'd48,  8'd44,  8'd40,  8'd36,  8'd32,  8'd30,  8'd28,  8'd26,
        8'd24,  8'd22,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd13
    };

    localparam logic [1:0] ORD_BAND_FIRST = 2'd0;
    localparam logic [1:0] ORD_LOW_FIRST  = 2'd1;
    localparam logic [1:0] FORM_SEPARATE  = 2'd0;
    localparam logic [1:0] FORM_JOINT     = 2'd1;
    localparam logic       QS_ROUND_FIRST = 1'b1;

    localparam logic [2:0] RM_FLOOR     = 3'd0;
    localparam logic [2:0] RM_TRUNC     = 3'd1;
    localparam logic [2:0] RM_HALF_AWAY = 3'd2;
    localparam logic [2:0] RM_HALF_UP   = 3'd3;
    localparam logic [2:0] RM_CEIL      = 3'd4;
    localparam logic [2:0] RM_AWAY      = 3'd5;

    typedef enum logic [2:0] {
        REG_FREQ_CODE     = 3'd0,
        REG_Q_INDEX       = 3'd1,
        REG_LOW_FRAC_BITS = 3'd2,
        REG_BAND_SHIFT    = 3'd3,
        REG_UPDATE_ORDER  = 3'd4,
        REG_PRODUCT_FORM  = 3'd5,
        REG_Q_SPLIT       = 3'd6,
        REG_ROUND_MODES   = 3'd7
    } t_reg;

    typedef struct packed {
        logic [12:0]        freq_code;
        logic [4:0]         q_index;
        logic [2:0]         low_frac_bits;
        logic signed [3:0]  band_shift;
        logic [1:0]         update_order;
        logic [1:0]         product_form;
        logic               q_split;
        logic [14:0]        round_modes;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_LOW_MUL, S_LOW_RND, S_LOW_ACC, S_LOW_WR,
        S_Q_MUL, S_Q_RND, S_Q2_MUL, S_Q2_RND, S_Q_ACC,
        S_FX_MUL, S_FX_RND, S_FX_ACC, S_FL_MUL, S_FL_RND, S_FL_ACC,
        S_J_MUL, S_J_MUL2, S_J_SUB, S_J_RND, S_J_ACC,
        S_BAND_WR, S_HOLD_WR, S_OUT_RND, S_OUT_WR
    } t_state;

    typedef enum logic [2:0] { MA_X, MA_LOW, MA_BAND, MA_XL, MA_RND } t_mul_a;
    typedef enum logic [1:0] { MB_K, MB_KQ, MB_QM } t_mul_b;
    typedef enum logic [1:0] { RSRC_PROD, RSRC_ACC, RSRC_LOW } t_rsrc;
    typedef enum logic [2:0] {
        RSH_X_SEP, RSH_X_JOINT, RSH_Q_COMB, RSH_Q_FIRST,
        RSH_Q_SECOND, RSH_SINGLE, RSH_LOW_UPD, RSH_OUT
    } t_rsh;
    typedef enum logic [2:0] { RMS_X, RMS_L, RMS_Q, RMS_U, RMS_O } t_rmsel;
    typedef enum logic [2:0] {
        ACC_HOLD, ACC_BAND_MINUS_RND, ACC_ADD_RND, ACC_SUB_RND,
        ACC_LOW_PLUS_RND, ACC_PROD_SHB, ACC_SUB_PROD_SHL, ACC_BAND_PLUS_RND
    } t_acc_op;
    typedef enum logic [2:0] { WR_NONE, WR_BAND, WR_LOW, WR_HOLD, WR_LOW_HOLD } t_wr_op;

    typedef struct packed {
        logic    x_load;
        logic    mul_en;
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        logic    rnd_en;
        t_rsrc   rnd_src;
        t_rsh    rnd_sh;
        t_rmsel  rnd_mode;
        t_acc_op acc_op;
        t_wr_op  wr_op;
        logic    out_load;
    } t_cmd;

endpackage

// ----- design/svf_regs.sv -----
// Configuration register file with its APB-style access port.
module svf_regs import svf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_reg wr_idx;

    assign pready = 1'b1;
    assign wr_idx = t_reg'(paddr[4:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{q_index: Q_INDEX_RESET, default: '0};
        end else if (psel && penable && pwrite) begin
            unique case (wr_idx)
                REG_FREQ_CODE:     r_cfg.freq_code     <= pwdata[12:0];
                REG_Q_INDEX:       r_cfg.q_index       <= pwdata[4:0];
                REG_LOW_FRAC_BITS: r_cfg.low_frac_bits <= pwdata[2:0];
                REG_BAND_SHIFT:    r_cfg.band_shift    <= signed'(pwdata[3:0]);
                REG_UPDATE_ORDER:  r_cfg.update_order  <= pwdata[1:0];
                REG_PRODUCT_FORM:  r_cfg.product_form  <= pwdata[1:0];
                REG_Q_SPLIT:       r_cfg.q_split       <= pwdata[0];
                REG_ROUND_MODES:   r_cfg.round_modes   <= pwdata[14:0];
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_FREQ_CODE:     prdata = 32'(r_cfg.freq_code);
            REG_Q_INDEX:       prdata = 32'(r_cfg.q_index);
            REG_LOW_FRAC_BITS: prdata = 32'(r_cfg.low_frac_bits);
            REG_BAND_SHIFT:    prdata = 32'(unsigned'(r_cfg.band_shift));
            REG_UPDATE_ORDER:  prdata = 32'(r_cfg.update_order);
            REG_PRODUCT_FORM:  prdata = 32'(r_cfg.product_form);
            REG_Q_SPLIT:       prdata = 32'(r_cfg.q_split);
            REG_ROUND_MODES:   prdata = 32'(r_cfg.round_modes);
        endcase
    end

endmodule

// ----- design/svf_ctrl.sv -----
// Sequencer that steps the shared multiplier, rounder and accumulator through one item.
module svf_ctrl import svf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   band_first, simult, form_single, form_sep, qs_first;
    t_state band_start;

    assign band_first  = (i_cfg.update_order == ORD_BAND_FIRST);
    assign simult      = i_cfg.update_order[1];
    assign form_single = i_cfg.product_form[1];
    assign form_sep    = (i_cfg.product_form == FORM_SEPARATE);
    assign qs_first    = (i_cfg.q_split == QS_ROUND_FIRST);
    assign band_start  = form_single ? S_J_MUL : S_Q_MUL;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.x_load = 1'b1;
                    n_state      = band_first ? band_start : S_LOW_MUL;
                end
            end
            S_LOW_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MA_BAND;
                o_cmd.mul_b  = MB_K;
                n_state      = S_LOW_RND;
            end
            S_LOW_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_PROD;
                o_cmd.rnd_sh   = RSH_LOW_UPD;
                o_cmd.rnd_mode = RMS_U;
                n_state        = S_LOW_ACC;
            end
            S_LOW_ACC: begin
                o_cmd.acc_op = ACC_LOW_PLUS_RND;
                n_state      = S_LOW_WR;
            end
            S_LOW_WR: begin
                o_cmd.wr_op = simult ? WR_HOLD : WR_LOW;
                n_state     = band_first ? S_OUT_RND : band_start;
            end
            S_Q_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MA_BAND;
                o_cmd.mul_b  = qs_first ? MB_QM : MB_KQ;
                n_state      = S_Q_RND;
            end
            S_Q_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_PROD;
                o_cmd.rnd_sh   = qs_first ? RSH_Q_FIRST : RSH_Q_COMB;
                o_cmd.rnd_mode = RMS_Q;
                n_state        = qs_first ? S_Q2_MUL : S_Q_ACC;
            end
            S_Q2_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MA_RND;
                o_cmd.mul_b  = MB_K;
                n_state      = S_Q2_RND;
            end
            S_Q2_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_PROD;
                o_cmd.rnd_sh   = RSH_Q_SECOND;
                o_cmd.rnd_mode = RMS_Q;
                n_state        = S_Q_ACC;
            end
            S_Q_ACC: begin
                o_cmd.acc_op = ACC_BAND_MINUS_RND;
                n_state      = S_FX_MUL;
            end
            S_FX_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = form_sep ? MA_X : MA_XL;
                o_cmd.mul_b  = MB_K;
                n_state      = S_FX_RND;
            end
            S_FX_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_PROD;
                o_cmd.rnd_sh   = form_sep ? RSH_X_SEP : RSH_X_JOINT;
                o_cmd.rnd_mode = RMS_X;
                n_state        = S_FX_ACC;
            end
            S_FX_ACC: begin
                o_cmd.acc_op = ACC_ADD_RND;
                n_state      = form_sep ? S_FL_MUL : S_BAND_WR;
            end
            S_FL_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MA_LOW;
                o_cmd.mul_b  = MB_K;
                n_state      = S_FL_RND;
            end
            S_FL_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_PROD;
                o_cmd.rnd_sh   = RSH_X_JOINT;
                o_cmd.rnd_mode = RMS_L;
                n_state        = S_FL_ACC;
            end
            S_FL_ACC: begin
                o_cmd.acc_op = ACC_SUB_RND;
                n_state      = S_BAND_WR;
            end
            S_J_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MA_XL;
                o_cmd.mul_b  = MB_K;
                n_state      = S_J_MUL2;
            end
            S_J_MUL2: begin
                o_cmd.acc_op = ACC_PROD_SHB;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_a  = MA_BAND;
                o_cmd.mul_b  = MB_KQ;
                n_state      = S_J_SUB;
            end
            S_J_SUB: begin
                o_cmd.acc_op = ACC_SUB_PROD_SHL;
                n_state      = S_J_RND;
            end
            S_J_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_ACC;
                o_cmd.rnd_sh   = RSH_SINGLE;
                o_cmd.rnd_mode = RMS_X;
                n_state        = S_J_ACC;
            end
            S_J_ACC: begin
                o_cmd.acc_op = ACC_BAND_PLUS_RND;
                n_state      = S_BAND_WR;
            end
            S_BAND_WR: begin
                o_cmd.wr_op = WR_BAND;
                if (band_first) begin
                    n_state = S_LOW_MUL;
                end else begin
                    n_state = simult ? S_HOLD_WR : S_OUT_RND;
                end
            end
            S_HOLD_WR: begin
                o_cmd.wr_op = WR_LOW_HOLD;
                n_state     = S_OUT_RND;
            end
            S_OUT_RND: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.rnd_src  = RSRC_LOW;
                o_cmd.rnd_sh   = RSH_OUT;
                o_cmd.rnd_mode = RMS_O;
                n_state        = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an item not yet taken");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=>
        (r_state == S_LOW_MUL || r_state == S_Q_MUL || r_state == S_J_MUL))
        else $error("accepted item did not start a product sequence");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_WR && r_out_valid && !i_out_ready) |=> (r_state == S_OUT_WR))
        else $error("finished item left the wait state while output was blocked");
`endif

endmodule

// ----- design/svf_dp.sv -----
// Datapath: filter state, shared multiplier, rounder, accumulator and output registers.
module svf_dp import svf_pkg::*; #(
    parameter int STATE_BITS   = DEF_STATE_BITS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int LOW_FRAC_MAX = DEF_LOW_FRAC_MAX
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic signed [OUT_BITS-1:0]    o_low_out,
    output logic signed [OUT_BITS-1:0]    o_band_out
);

    localparam int XW   = ((STATE_BITS > SAMPLE_BITS + LOW_FRAC_MAX) ?
                           STATE_BITS : SAMPLE_BITS + LOW_FRAC_MAX) + 1;
    localparam int PW   = XW + KQ_BITS + 1;
    localparam int LSHW = (HB_MAX + Q_FRAC > LOW_FRAC_MAX) ? HB_MAX + Q_FRAC : LOW_FRAC_MAX;
    localparam int W    = PW + LSHW + 1;

    localparam logic signed [W-1:0] ST_MAX_W  = W'({1'b0, {(STATE_BITS-1){1'b1}}});
    localparam logic signed [W-1:0] ST_MIN_W  = -ST_MAX_W - W'(1);
    localparam logic signed [W-1:0] OUT_MAX_W = W'({1'b0, {(OUT_BITS-1){1'b1}}});
    localparam logic signed [W-1:0] OUT_MIN_W = -OUT_MAX_W - W'(1);
    localparam logic signed [STATE_BITS-1:0] OUT_MAX_S =
        STATE_BITS'({1'b0, {(OUT_BITS-1){1'b1}}});
    localparam logic signed [STATE_BITS-1:0] OUT_MIN_S = -OUT_MAX_S - STATE_BITS'(1);

    logic signed [STATE_BITS-1:0]  r_low, r_band, r_hold;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PW-1:0]          r_prod;
    logic signed [W-1:0]           r_rnd, r_acc, n_acc;
    logic [KQ_BITS-1:0]            r_kq;
    logic signed [OUT_BITS-1:0]    r_low_out, r_band_out;

    logic [3:0]               e;
    logic [K_BITS-1:0]        k;
    logic [QM_BITS-1:0]       qm;
    logic signed [6:0]        sh, hb7, hl7, rsh;
    logic [3:0]               hl;
    logic signed [3:0]        hb;
    logic [3:0]               shb;
    logic signed [XW-1:0]     xs, xl, mul_a;
    logic [KQ_BITS-1:0]       mul_b;
    logic signed [KQ_BITS:0]  mul_bs;
    logic signed [PW-1:0]     mul_res;
    logic signed [W-1:0]      rv, fl, rnd_res, hmask, below;
    logic [5:0]               sa;
    logic [2:0]               mode;
    logic                     neg, half_bit, below_nz, frac_nz, inc;
    logic signed [STATE_BITS-1:0] sat_acc;
    logic signed [OUT_BITS-1:0]   sat_low, sat_band;

    // tuning decode
    assign e   = i_cfg.freq_code[12:9];
    assign k   = K_BASE + K_BITS'((i_cfg.freq_code & FREQ_MANT_MASK) >> 1);
    assign qm  = Q_TABLE[i_cfg.q_index];
    assign sh  = 7'(SH_BASE) - signed'({3'b000, e});
    assign hl  = ({1'b0, i_cfg.low_frac_bits} > 4'(LOW_FRAC_MAX)) ?
                 4'(LOW_FRAC_MAX) : {1'b0, i_cfg.low_frac_bits};
    assign hb  = (i_cfg.band_shift < -4'sd2) ? -4'sd2 :
                 (i_cfg.band_shift > 4'sd4)  ?  4'sd4 : i_cfg.band_shift;
    assign hb7 = 7'(hb);
    assign hl7 = signed'({3'b000, hl});
    assign shb = 4'(hb) + 4'(Q_FRAC);

    assign xs = XW'(r_x);
    assign xl = (xs <<< hl) - XW'(r_low);

    always_comb begin
        case (i_cmd.mul_a)
            MA_X:    mul_a = xs;
            MA_LOW:  mul_a = XW'(r_low);
            MA_BAND: mul_a = XW'(r_band);
            MA_XL:   mul_a = xl;
            default: mul_a = XW'(r_rnd);
        endcase
        case (i_cmd.mul_b)
            MB_K:    mul_b = KQ_BITS'(k);
            MB_KQ:   mul_b = r_kq;
            default: mul_b = KQ_BITS'(qm);
        endcase
    end

    assign mul_bs  = signed'({1'b0, mul_b});
    assign mul_res = mul_a * mul_bs;

    // rounder
    always_comb begin
        case (i_cmd.rnd_src)
            RSRC_PROD: rv = W'(r_prod);
            RSRC_ACC:  rv = r_acc;
            default:   rv = W'(r_low);
        endcase
        case (i_cmd.rnd_sh)
            RSH_X_SEP:    rsh = sh - hb7;
            RSH_X_JOINT:  rsh = sh - hb7 + hl7;
            RSH_Q_COMB:   rsh = sh + 7'(Q_FRAC);
            RSH_Q_FIRST:  rsh = 7'(Q_FRAC);
            RSH_Q_SECOND: rsh = sh;
            RSH_SINGLE:   rsh = sh + 7'(Q_FRAC) + hl7;
            RSH_LOW_UPD:  rsh = sh + hb7 - hl7;
            default:      rsh = hl7;
        endcase
        case (i_cmd.rnd_mode)
            RMS_X:   mode = i_cfg.round_modes[2:0];
            RMS_L:   mode = i_cfg.round_modes[5:3];
            RMS_Q:   mode = i_cfg.round_modes[8:6];
            RMS_U:   mode = i_cfg.round_modes[11:9];
            default: mode = i_cfg.round_modes[14:12];
        endcase
        neg      = rv[W-1];
        sa       = (rsh > 7'sd0) ? 6'(rsh) : 6'd1;
        fl       = rv >>> sa;
        hmask    = W'(1) << (sa - 6'd1);
        below    = rv & (hmask - W'(1));
        half_bit = |(rv & hmask);
        below_nz = |below;
        frac_nz  = half_bit | below_nz;
        case (mode)
            RM_FLOOR:     inc = 1'b0;
            RM_TRUNC:     inc = neg & frac_nz;
            RM_HALF_AWAY: inc = neg ? (half_bit & below_nz) : half_bit;
            RM_HALF_UP:   inc = half_bit;
            RM_CEIL:      inc = frac_nz;
            RM_AWAY:      inc = !neg & frac_nz;
            default:      inc = half_bit & (below_nz | fl[0]);
        endcase
        if (rsh > 7'sd0) begin
            rnd_res = fl + signed'({{(W-1){1'b0}}, inc});
        end else begin
            rnd_res = rv <<< 6'(-rsh);
        end
    end

    always_comb begin
        case (i_cmd.acc_op)
            ACC_BAND_MINUS_RND: n_acc = W'(r_band) - r_rnd;
            ACC_ADD_RND:        n_acc = r_acc + r_rnd;
            ACC_SUB_RND:        n_acc = r_acc - r_rnd;
            ACC_LOW_PLUS_RND:   n_acc = W'(r_low) + r_rnd;
            ACC_PROD_SHB:       n_acc = W'(r_prod) <<< shb;
            ACC_SUB_PROD_SHL:   n_acc = r_acc - (W'(r_prod) <<< hl);
            ACC_BAND_PLUS_RND:  n_acc = W'(r_band) + r_rnd;
            default:            n_acc = r_acc;
        endcase
    end

    assign sat_acc  = (r_acc > ST_MAX_W) ? STATE_BITS'(ST_MAX_W) :
                      (r_acc < ST_MIN_W) ? STATE_BITS'(ST_MIN_W) : STATE_BITS'(r_acc);
    assign sat_low  = (r_rnd > OUT_MAX_W) ? OUT_BITS'(OUT_MAX_W) :
                      (r_rnd < OUT_MIN_W) ? OUT_BITS'(OUT_MIN_W) : OUT_BITS'(r_rnd);
    assign sat_band = (r_band > OUT_MAX_S) ? OUT_BITS'(OUT_MAX_S) :
                      (r_band < OUT_MIN_S) ? OUT_BITS'(OUT_MIN_S) : OUT_BITS'(r_band);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_band <= '0;
        end else begin
            case (i_cmd.wr_op)
                WR_BAND:     r_band <= sat_acc;
                WR_LOW:      r_low  <= sat_acc;
                WR_LOW_HOLD: r_low  <= r_hold;
                default:     r_low  <= r_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_kq  <= KQ_BITS'(k * qm);
        r_acc <= n_acc;
        if (i_cmd.wr_op == WR_HOLD) begin
            r_hold <= sat_acc;
        end
        if (i_cmd.x_load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_res;
        end
        if (i_cmd.rnd_en) begin
            r_rnd <= rnd_res;
        end
        if (i_cmd.out_load) begin
            r_low_out  <= sat_low;
            r_band_out <= sat_band;
        end
    end

    assign o_low_out  = r_low_out;
    assign o_band_out = r_band_out;

endmodule

// ----- design/state_variable_filter_step_top.sv -----
// Top level of the state-variable filter step block.
// One sample item in, one low/band result item out. The states from acceptance until
// the result stands in the output register are fewest for the single-rounding
// product form with band-first or low-first update, and most for separate products
// with the q product rounded first under simultaneous update. The one shared
// multiplier and rounder take every product in turn, each with a multiply, a round
// and an accumulate step; the single-rounding form multiplies both and rounds once.
// A finished item waits further while the previous result has not been taken.
// The next item is accepted as soon as the result is registered, while that result
// still waits to be taken. Configuration is to be written through the APB-style port
// only while the block is idle: a rule for the user, not enforced by the block.
module state_variable_filter_step_top import svf_pkg::*; #(
    parameter int STATE_BITS   = DEF_STATE_BITS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int LOW_FRAC_MAX = DEF_LOW_FRAC_MAX
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [OUT_BITS-1:0]    o_low_out,
    output logic signed [OUT_BITS-1:0]    o_band_out
);

    t_cfg cfg;
    t_cmd cmd;

    svf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    svf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    svf_dp #(
        .STATE_BITS   (STATE_BITS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .LOW_FRAC_MAX (LOW_FRAC_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_sample_in (i_sample_in),
        .o_low_out   (o_low_out),
        .o_band_out  (o_band_out)
    );

endmodule

// ----- dv/svf_filter_checker.sv -----
// Checker that predicts and compares the low and band results of the state-variable filter step.
`timescale 1ns / 1ps
module svf_filter_checker import svf_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [DEF_SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [OUT_BITS-1:0]    i_low_out,
    input  logic signed [OUT_BITS-1:0]    i_band_out,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] low_out;
        logic signed [OUT_BITS-1:0] band_out;
    } t_filter_out;

    t_cfg        cfg;
    t_wide       low_acc;
    t_wide       band_acc;
    t_filter_out expected_outs[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_outs.size();

    function automatic t_wide round_to(t_wide v, int sh, logic [2:0] mode);
        t_wide a, r, fl, h, m, fr;
        logic  neg;
        if (sh <= 0) return v <<< (-sh);
        if (sh > 63) sh = 63;
        h   = t_wide'(1) <<< (sh - 1);
        m   = (t_wide'(1) <<< sh) - 1;
        neg = v[127];
        a   = neg ? -v : v;
        case (mode)
            RM_FLOOR:     return v >>> sh;
            RM_TRUNC:     r = a >>> sh;
            RM_HALF_AWAY: r = (a + h) >>> sh;
            RM_HALF_UP:   return (v + h) >>> sh;
            RM_CEIL:      return -((-v) >>> sh);
            RM_AWAY:      r = (a + m) >>> sh;
            default: begin
                fl = v >>> sh;
                fr = v & m;
                if (fr > h || (fr == h && fl[0])) fl = fl + 1;
                return fl;
            end
        endcase
        return neg ? -r : r;
    endfunction

    function automatic t_wide clamp_bits(t_wide v, int bits);
        t_wide mx, mn;
        mx = (t_wide'(1) <<< (bits - 1)) - 1;
        mn = -mx - 1;
        if (v > mx) return mx;
        if (v < mn) return mn;
        return v;
    endfunction

    function automatic t_wide band_update(t_wide lowv, t_wide band, t_wide x, t_wide k,
                                          t_wide qm, int sh, int hl, int hb,
                                          logic [2:0] rx, logic [2:0] rl, logic [2:0] rq);
        t_wide qt, xl, num;
        xl = (x <<< hl) - lowv;
        if (cfg.product_form != FORM_SEPARATE && cfg.product_form != FORM_JOINT) begin
            num = ((xl <<< (hb + 7)) * k) - ((band * (k * qm)) <<< hl);
            return band + round_to(num, sh + 7 + hl, rx);
        end
        if (cfg.q_split != QS_ROUND_FIRST) qt = round_to(band * (k * qm), sh + 7, rq);
        else qt = round_to(round_to(band * qm, 7, rq) * k, sh, rq);
        if (cfg.product_form == FORM_SEPARATE)
            return band + round_to(x * k, sh - hb, rx)
                        - round_to(lowv * k, sh - hb + hl, rl) - qt;
        return band + round_to(xl * k, sh - hb + hl, rx) - qt;
    endfunction

    task automatic filter_step(input t_wide x);
        t_wide       k, qm, nl;
        int          sh, hl, hb;
        logic [2:0]  rx, rl, rq, ru, ro;
        t_filter_out res;
        k  = 256 + cfg.freq_code[8:1];
        qm = Q_TABLE[cfg.q_index];
        sh = 24 - int'(cfg.freq_code[12:9]);
        hl = cfg.low_frac_bits > DEF_LOW_FRAC_MAX ? DEF_LOW_FRAC_MAX : int'(cfg.low_frac_bits);
        hb = int'(cfg.band_shift);
        if (hb < -2) hb = -2;
        if (hb > HB_MAX) hb = HB_MAX;
        {ro, ru, rq, rl, rx} = cfg.round_modes;
        nl = clamp_bits(low_acc + round_to(band_acc * k, sh + hb - hl, ru), DEF_STATE_BITS);
        if (cfg.update_order == ORD_BAND_FIRST) begin
            band_acc = clamp_bits(band_update(low_acc, band_acc, x, k, qm, sh, hl, hb, rx, rl, rq),
                                  DEF_STATE_BITS);
            low_acc  = clamp_bits(low_acc + round_to(band_acc * k, sh + hb - hl, ru),
                                  DEF_STATE_BITS);
        end else if (cfg.update_order == ORD_LOW_FIRST) begin
            low_acc  = nl;
            band_acc = clamp_bits(band_update(low_acc, band_acc, x, k, qm, sh, hl, hb, rx, rl, rq),
                                  DEF_STATE_BITS);
        end else begin
            band_acc = clamp_bits(band_update(low_acc, band_acc, x, k, qm, sh, hl, hb, rx, rl, rq),
                                  DEF_STATE_BITS);
            low_acc  = nl;
        end
        res.low_out  = OUT_BITS'(clamp_bits(round_to(low_acc, hl, ro), OUT_BITS));
        res.band_out = OUT_BITS'(clamp_bits(band_acc, OUT_BITS));
        expected_outs.insert(expected_outs.size(), res);
    endtask

    always @(posedge i_clk) begin
        t_filter_out want;
        if (!i_rst_n) begin
            cfg          <= '{q_index: Q_INDEX_RESET, default: '0};
            low_acc      = '0;
            band_acc     = '0;
            fails        = 0;
            expected_outs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[4:2]))
                    REG_FREQ_CODE:     cfg.freq_code     <= pwdata[12:0];
                    REG_Q_INDEX:       cfg.q_index       <= pwdata[4:0];
                    REG_LOW_FRAC_BITS: cfg.low_frac_bits <= pwdata[2:0];
                    REG_BAND_SHIFT:    cfg.band_shift    <= pwdata[3:0];
                    REG_UPDATE_ORDER:  cfg.update_order  <= pwdata[1:0];
                    REG_PRODUCT_FORM:  cfg.product_form  <= pwdata[1:0];
                    REG_Q_SPLIT:       cfg.q_split       <= pwdata[0];
                    default:           cfg.round_modes   <= pwdata[14:0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_outs.size() == 0) begin
                    $error("result item with nothing expected: low %0d band %0d",
                           i_low_out, i_band_out);
                    fails++;
                end else begin
                    want = expected_outs.pop_front();
                    if (i_low_out !== want.low_out) begin
                        $error("low_out expected %0d actual %0d", want.low_out, i_low_out);
                        fails++;
                    end
                    if (i_band_out !== want.band_out) begin
                        $error("band_out expected %0d actual %0d", want.band_out, i_band_out);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) filter_step(t_wide'(i_sample_in));
        end
    end

endmodule

// ----- dv/tb_state_variable_filter_step_top.sv -----
// Stimulus and verdict for the state-variable filter step block.
`timescale 1ns / 1ps
module tb_state_variable_filter_step_top;
    import svf_pkg::*;

    localparam logic [1:0] ORD_SPARE        = 2'd3;
    localparam logic [1:0] FORM_SPARE       = 2'd3;
    localparam int         S_MAX            = (1 << (DEF_SAMPLE_BITS - 1)) - 1;
    localparam int         S_MIN            = -(1 << (DEF_SAMPLE_BITS - 1));

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic signed [DEF_SAMPLE_BITS-1:0] i_sample_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [OUT_BITS-1:0] o_low_out;
    logic signed [OUT_BITS-1:0] o_band_out;
    int          fail_count;
    int          pending;
    bit          send_calm;

    always #1 i_clk = ~i_clk;

    state_variable_filter_step_top u_top (.*);

    svf_filter_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_sample_in,
        .i_out_valid(o_out_valid), .i_out_ready, .i_low_out(o_low_out),
        .i_band_out(o_band_out), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls with calm stretches
    initial begin
        int stall;
        int run;
        bit calm;
        run = 0;
        calm = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (run == 0) begin
                run  = $urandom_range(10, 60);
                calm = ($urandom_range(0, 3) == 0);
            end
            run--;
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    task automatic reg_write(input t_reg r, input logic [31:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic filter_setup(input logic [12:0] freq, input logic [4:0] q,
                                input logic [2:0] lf, input logic [3:0] bs,
                                input logic [1:0] ord, input logic [1:0] form,
                                input logic qs, input logic [14:0] rm);
        // let the block drain before touching its registers
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        reg_write(REG_FREQ_CODE, 32'(freq));
        reg_write(REG_Q_INDEX, 32'(q));
        reg_write(REG_LOW_FRAC_BITS, 32'(lf));
        reg_write(REG_BAND_SHIFT, 32'(bs));
        reg_write(REG_UPDATE_ORDER, 32'(ord));
        reg_write(REG_PRODUCT_FORM, 32'(form));
        reg_write(REG_Q_SPLIT, 32'(qs));
        reg_write(REG_ROUND_MODES, 32'(rm));
    endtask

    task automatic send_sample(input int x);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_sample_in = DEF_SAMPLE_BITS'(x);
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    initial begin
        int n;
        int style;
        int level;
        int x;
        logic [12:0] freq;
        send_calm = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: full-scale steps and values around zero
        repeat (4) send_sample(S_MAX);
        repeat (4) send_sample(S_MIN);
        send_sample(0);
        send_sample(-1);
        send_sample(1);

        // every field at its top code but the band shift at its most negative, spare codes and out-of-range clamps
        filter_setup(13'h1FFF, 5'd31, 3'd7, 4'h8, ORD_SPARE, FORM_SPARE, QS_ROUND_FIRST, 15'h7FFF);
        repeat (3) send_sample(S_MAX);
        repeat (3) send_sample(S_MIN);

        filter_setup(13'd0, 5'd0, 3'd4, 4'h7, ORD_LOW_FIRST, FORM_JOINT, 1'b0, 15'h2492);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? S_MIN : S_MAX);

        for (int ph = 0; ph < 24; ph++) begin
            freq = 13'($urandom_range(0, 8191));
            if ($urandom_range(0, 2) != 0) freq[12:9] = 4'($urandom_range(0, 9));
            filter_setup(freq, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                         4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         15'($urandom_range(0, 32767)));
            send_calm = ($urandom_range(0, 3) == 0);
            style = $urandom_range(0, 2);
            n = $urandom_range(50, 85);
            level = 0;
            for (int i = 0; i < n; i++) begin
                case (style)
                    0: x = $urandom_range(0, 262143) - 131072;
                    1: x = $urandom_range(0, 128) - 64;
                    default: begin
                        // hold a level for a run, then jump
                        if ($urandom_range(0, 11) == 0)
                            level = $urandom_range(0, 262143) - 131072;
                        x = level;
                    end
                endcase
                send_sample(x);
            end
        end

        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
